/* sv/gmep_pkg.sv */
// Shared constants for the grid minimum effort path block.
package gmep_pkg;

    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_HEIGHT_BITS = 16;

    localparam int FIELD_BITS = 16;   // height and effort port width
    localparam int SIZE_BITS  = 7;    // grid_rows / grid_cols register width

    // configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // neighbor visit order
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

endpackage

/* sv/gmep_relax.sv */
// Shared relax unit: absolute height step, path max, and improvement compare.
module gmep_relax
    import gmep_pkg::*;
#(
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
    input  logic [HEIGHT_BITS-1:0] from_height,
    input  logic [HEIGHT_BITS-1:0] nb_height,
    input  logic [HEIGHT_BITS:0]   from_cost,
    input  logic [HEIGHT_BITS:0]   nb_cost,
    output logic [HEIGHT_BITS:0]   new_cost,
    output logic                   improve
);

    logic [HEIGHT_BITS-1:0] step;
    logic [HEIGHT_BITS:0]   step_ext;

    always_comb
    begin
        if (from_height > nb_height)
        begin
            step = from_height - nb_height;
        end
        else
        begin
            step = nb_height - from_height;
        end
        step_ext = {1'b0, step};
        new_cost = (from_cost > step_ext) ? from_cost : step_ext;
        improve  = nb_cost > new_cost;
    end

endmodule

/* sv/grid_min_effort_path.sv */
// Grid minimum effort path: cell loader, worklist sequencer and result register.
//
// Usage: set grid_rows (index 0) and grid_cols (index 1) on the cfg port while
// idle; 0 acts as 1 and values above the maximum saturate. Then send heights
// on the cell channel in row-major order, one word per cycle. Cells past
// rows*cols are dropped. The word with last high starts the solve.
// Solve: reset the cost and in-list memories for all rows*cols cells, a seed
// step, then per dequeued cell a pop, fetch and source read plus a neighbor read
// per direction and a relax per present neighbor, then a read-out of the bottom-right cost.
// All of it runs through one relax unit and one read port per memory, and
// cell_ready stays low throughout.
// The effort word sits in an output register; loading of the next grid
// proceeds while it waits for effort_ready. A later solve holds its result
// until that register is free.
// Reset clears the sequencer, the size registers (to 1) and the load index.
// Height contents are undefined until loaded.
module grid_min_effort_path
    import gmep_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [SIZE_BITS-1:0]  cfg_wdata,
    input  logic                  cell_valid,
    output logic                  cell_ready,
    input  logic [FIELD_BITS-1:0] height,
    input  logic                  last,
    output logic                  effort_valid,
    input  logic                  effort_ready,
    output logic [FIELD_BITS-1:0] effort
);

    localparam int MAX_CELLS = MAX_ROWS * MAX_COLS;
    localparam int CLW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int HB  = HEIGHT_BITS;
    localparam logic [HB:0] COST_NONE = '1;

    typedef struct packed {
        logic [CLW-1:0] addr;
        logic [RIW-1:0] r;
        logic [CIW-1:0] c;
    } entry_t;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CLEAR  = 9'b000000010,
        S_SEED   = 9'b000000100,
        S_POP    = 9'b000001000,
        S_FETCH  = 9'b000010000,
        S_FROM   = 9'b000100000,
        S_NREAD  = 9'b001000000,
        S_RELAX  = 9'b010000000,
        S_RESULT = 9'b100000000
    } state_t;

    // memories
    logic [HB-1:0] height_mem [MAX_CELLS];
    logic [HB:0]   cost_mem   [MAX_CELLS];
    logic          flag_mem   [MAX_CELLS];
    entry_t        list_mem   [MAX_CELLS];

    logic           h_we, h_re, c_we, c_re, f_we, f_re, l_we, l_re;
    logic [CLW-1:0] h_waddr, h_raddr, c_waddr, c_raddr, f_waddr, f_raddr;
    logic [CLW-1:0] l_waddr, l_raddr;
    logic [HB-1:0]  h_wdata, h_rdata_reg;
    logic [HB:0]    c_wdata, c_rdata_reg;
    logic           f_wdata, f_rdata_reg;
    entry_t         l_wdata, l_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (h_we) height_mem[h_waddr] <= h_wdata;
        if (h_re) h_rdata_reg <= height_mem[h_raddr];
        if (c_we) cost_mem[c_waddr] <= c_wdata;
        if (c_re) c_rdata_reg <= cost_mem[c_raddr];
        if (f_we) flag_mem[f_waddr] <= f_wdata;
        if (f_re) f_rdata_reg <= flag_mem[f_raddr];
        if (l_we) list_mem[l_waddr] <= l_wdata;
        if (l_re) l_rdata_reg <= list_mem[l_raddr];
    end

    // control registers
    state_t          state_reg, state_next;
    logic [RW-1:0]   rows_reg, rows_next;
    logic [CW-1:0]   cols_reg, cols_next;
    logic [CLW:0]    load_idx_reg, load_idx_next;
    logic [CLW-1:0]  last_idx_reg, last_idx_next;
    logic [CLW-1:0]  clr_reg, clr_next;
    logic [CLW-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [CLW:0]    count_reg, count_next;
    logic [1:0]      dir_reg, dir_next;
    entry_t          cur_reg, cur_next;
    entry_t          nb_reg, nb_next;
    logic [HB-1:0]   from_h_reg, from_h_next;
    logic [HB:0]     from_cost_reg, from_cost_next;
    logic            out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0] effort_reg, effort_next;

    logic [31:0]     cells_now;
    logic [31:0]     cfg32, h32, res32;
    logic [HB-1:0]   h_in;
    entry_t          nb_cand;
    logic            nb_ok;
    logic [HB:0]     relax_cost;
    logic            relax_improve;

    gmep_relax #(.HEIGHT_BITS(HB)) u_relax (
        .from_height (from_h_reg),
        .nb_height   (h_rdata_reg),
        .from_cost   (from_cost_reg),
        .nb_cost     (c_rdata_reg),
        .new_cost    (relax_cost),
        .improve     (relax_improve)
    );

    function automatic logic [CLW-1:0] ptr_inc(input logic [CLW-1:0] p);
        logic [CLW-1:0] q;
        if (32'(p) == MAX_CELLS - 1) q = '0;
        else q = p + 1'b1;
        return q;
    endfunction

    always_comb
    begin
        cells_now = 32'(rows_reg) * 32'(cols_reg);
        cfg32     = 32'(cfg_wdata);
        h32       = 32'(height);
        h_in      = h32[HB-1:0];
        res32     = 32'(c_rdata_reg);

        // neighbor of the current cell in direction dir_reg
        nb_cand = cur_reg;
        nb_ok   = 1'b0;
        case (dir_reg)
            DIR_UP:
            begin
                nb_ok        = cur_reg.r != '0;
                nb_cand.addr = cur_reg.addr - CLW'(cols_reg);
                nb_cand.r    = cur_reg.r - 1'b1;
            end
            DIR_RIGHT:
            begin
                nb_ok        = (32'(cur_reg.c) + 1) < 32'(cols_reg);
                nb_cand.addr = cur_reg.addr + 1'b1;
                nb_cand.c    = cur_reg.c + 1'b1;
            end
            DIR_DOWN:
            begin
                nb_ok        = (32'(cur_reg.r) + 1) < 32'(rows_reg);
                nb_cand.addr = cur_reg.addr + CLW'(cols_reg);
                nb_cand.r    = cur_reg.r + 1'b1;
            end
            default:
            begin
                nb_ok        = cur_reg.c != '0;
                nb_cand.addr = cur_reg.addr - 1'b1;
                nb_cand.c    = cur_reg.c - 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        load_idx_next  = load_idx_reg;
        last_idx_next  = last_idx_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        dir_next       = dir_reg;
        cur_next       = cur_reg;
        nb_next        = nb_reg;
        from_h_next    = from_h_reg;
        from_cost_next = from_cost_reg;
        out_valid_next = out_valid_reg;
        effort_next    = effort_reg;

        h_we = 1'b0; h_waddr = load_idx_reg[CLW-1:0]; h_wdata = h_in;
        h_re = 1'b0; h_raddr = nb_cand.addr;
        c_we = 1'b0; c_waddr = clr_reg; c_wdata = COST_NONE;
        c_re = 1'b0; c_raddr = nb_cand.addr;
        f_we = 1'b0; f_waddr = clr_reg; f_wdata = 1'b0;
        f_re = 1'b0; f_raddr = nb_cand.addr;
        l_we = 1'b0; l_waddr = tail_reg; l_wdata = nb_reg;
        l_re = 1'b0; l_raddr = head_reg;

        cell_ready = state_reg == S_IDLE;

        if (out_valid_reg && effort_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS:
                begin
                    if (cfg32 == 0) rows_next = RW'(1);
                    else if (cfg32 > MAX_ROWS) rows_next = RW'(MAX_ROWS);
                    else rows_next = RW'(cfg32);
                end
                default:
                begin
                    if (cfg32 == 0) cols_next = CW'(1);
                    else if (cfg32 > MAX_COLS) cols_next = CW'(MAX_COLS);
                    else cols_next = CW'(cfg32);
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cell_valid)
                begin
                    h_we = 32'(load_idx_reg) < cells_now;
                    if (32'(load_idx_reg) < MAX_CELLS)
                    begin
                        load_idx_next = load_idx_reg + 1'b1;
                    end
                    if (last)
                    begin
                        last_idx_next = CLW'(cells_now - 1);
                        clr_next      = '0;
                        state_next    = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                c_we = 1'b1;
                f_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == last_idx_reg)
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                c_we = 1'b1; c_waddr = '0; c_wdata = '0;
                f_we = 1'b1; f_waddr = '0; f_wdata = 1'b1;
                l_we = 1'b1; l_waddr = '0; l_wdata = '0;
                head_next  = '0;
                tail_next  = ptr_inc('0);
                count_next = (CLW+1)'(1);
                state_next = S_POP;
            end
            S_POP:
            begin
                if (count_reg == '0)
                begin
                    c_re = 1'b1; c_raddr = last_idx_reg;
                    state_next = S_RESULT;
                end
                else
                begin
                    l_re = 1'b1;
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cur_next = l_rdata_reg;
                h_re = 1'b1; h_raddr = l_rdata_reg.addr;
                c_re = 1'b1; c_raddr = l_rdata_reg.addr;
                f_we = 1'b1; f_waddr = l_rdata_reg.addr; f_wdata = 1'b0;
                state_next = S_FROM;
            end
            S_FROM:
            begin
                from_h_next    = h_rdata_reg;
                from_cost_next = c_rdata_reg;
                dir_next       = DIR_UP;
                state_next     = S_NREAD;
            end
            S_NREAD:
            begin
                nb_next = nb_cand;
                if (nb_ok)
                begin
                    h_re = 1'b1;
                    c_re = 1'b1;
                    f_re = 1'b1;
                    state_next = S_RELAX;
                end
                else if (dir_reg == DIR_LEFT)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dir_next = dir_reg + 1'b1;
                end
            end
            S_RELAX:
            begin
                if (relax_improve)
                begin
                    c_we = 1'b1; c_waddr = nb_reg.addr; c_wdata = relax_cost;
                    if (!f_rdata_reg)
                    begin
                        f_we = 1'b1; f_waddr = nb_reg.addr; f_wdata = 1'b1;
                        l_we = 1'b1;
                        tail_next  = ptr_inc(tail_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                if (dir_reg == DIR_LEFT)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dir_next   = dir_reg + 1'b1;
                    state_next = S_NREAD;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || effort_ready)
                begin
                    out_valid_next = 1'b1;
                    effort_next    = res32[FIELD_BITS-1:0];
                    load_idx_next  = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_reg      <= RW'(1);
            cols_reg      <= CW'(1);
            load_idx_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            load_idx_reg  <= load_idx_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_idx_reg  <= last_idx_next;
        clr_reg       <= clr_next;
        dir_reg       <= dir_next;
        cur_reg       <= cur_next;
        nb_reg        <= nb_next;
        from_h_reg    <= from_h_next;
        from_cost_reg <= from_cost_next;
        effort_reg    <= effort_next;
    end

    assign effort_valid = out_valid_reg;
    assign effort       = effort_reg;

endmodule

/* sim/testbench.sv */
// Testbench for grid_min_effort_path: random grids, predicted minimax efforts, scoreboard check.
`timescale 1ns / 1ps

class effort_board;
    int unsigned pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    function void note(int unsigned e);
        pending.push_back(e);
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task check(logic [15:0] got);
        int unsigned exp_e;
        if (pending.size() == 0)
        begin
            report($sformatf("effort %0d with no word expected", got));
        end
        else
        begin
            exp_e = pending.pop_front();
            if (got !== exp_e[15:0])
                report($sformatf("effort got %0d want %0d", got, exp_e));
        end
    endtask
endclass

module testbench;
    import gmep_pkg::*;

    localparam int CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;
    localparam int COST_NONE = 131071;
    localparam longint CYCLE_LIMIT = 4000000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_ROWS;
    logic [SIZE_BITS-1:0]  cfg_wdata = '0;
    logic                  cell_valid = 1'b0;
    logic                  cell_ready;
    logic [FIELD_BITS-1:0] height = '0;
    logic                  last = 1'b0;
    logic                  effort_valid;
    logic                  effort_ready = 1'b0;
    logic [FIELD_BITS-1:0] effort;

    grid_min_effort_path i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .cell_valid(cell_valid), .cell_ready(cell_ready),
        .height(height), .last(last),
        .effort_valid(effort_valid), .effort_ready(effort_ready), .effort(effort)
    );

    always #5 clk = ~clk;

    effort_board board = new();

    // grid model state
    logic [SIZE_BITS-1:0] rows_reg = 7'd1;
    logic [SIZE_BITS-1:0] cols_reg = 7'd1;
    logic [15:0] grid_h [CELLS];
    bit          loaded [CELLS];
    int unsigned cost [CELLS];
    bit          queued [CELLS];
    int          load_pos = 0;
    int          wl[$];

    int  items_sent = 0;
    int  burst_left = 10;
    bit  hold_req = 1'b0;
    longint cycles = 0;

    function automatic int clamp_dim(logic [SIZE_BITS-1:0] v, int lim);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : int'(v);
    endfunction

    function automatic void relax(int from, int to);
        int unsigned a, b, stp, c;
        a = grid_h[from];
        b = grid_h[to];
        stp = (a > b) ? a - b : b - a;
        c = (cost[from] > stp) ? cost[from] : stp;
        if (cost[to] > c)
        begin
            cost[to] = c;
            if (!queued[to])
            begin
                queued[to] = 1'b1;
                wl.push_back(to);
            end
        end
    endfunction

    function automatic int unsigned min_effort(int nr, int nc);
        int cur, r, c;
        for (int i = 0; i < CELLS; i++)
        begin
            cost[i] = COST_NONE;
            queued[i] = 1'b0;
        end
        wl.delete();
        cost[0] = 0;
        queued[0] = 1'b1;
        wl.push_back(0);
        while (wl.size() != 0)
        begin
            cur = wl.pop_front();
            queued[cur] = 1'b0;
            r = cur / nc;
            c = cur % nc;
            if (r > 0) relax(cur, cur - nc);
            if (c + 1 < nc) relax(cur, cur + 1);
            if (r + 1 < nr) relax(cur, cur + nc);
            if (c > 0) relax(cur, cur - 1);
        end
        return cost[nr * nc - 1] & 16'hFFFF;
    endfunction

    function automatic void take_cell(logic [15:0] h, logic l);
        int nr, nc;
        nr = clamp_dim(rows_reg, DEF_MAX_ROWS);
        nc = clamp_dim(cols_reg, DEF_MAX_COLS);
        if (load_pos < nr * nc)
        begin
            grid_h[load_pos] = h;
            loaded[load_pos] = 1'b1;
        end
        if (load_pos < CELLS)
            load_pos++;
        if (l)
        begin
            board.note(min_effort(nr, nc));
            load_pos = 0;
        end
    endfunction

    task send_cell(logic [15:0] h, logic l);
        cell_valid <= 1'b1;
        height <= h;
        last <= l;
        do @(posedge clk); while (!cell_ready);
        take_cell(h, l);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            cell_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task wait_drained();
        cell_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task write_reg(logic idx, logic [SIZE_BITS-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ROWS)
            rows_reg = v;
        else
            cols_reg = v;
    endtask

    task set_size(logic [SIZE_BITS-1:0] r, logic [SIZE_BITS-1:0] c);
        wait_drained();
        write_reg(REG_ROWS, r);
        write_reg(REG_COLS, c);
    endtask

    function automatic logic [15:0] pick_height(int style);
        case (style)
            0: return 16'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    // one grid: full, with extra cells, or short when the tail is already loaded
    task send_grid();
        int ncell, n, style, shape;
        bit tail_ok;
        ncell = clamp_dim(rows_reg, DEF_MAX_ROWS) * clamp_dim(cols_reg, DEF_MAX_COLS);
        style = $urandom_range(0, 3);
        shape = $urandom_range(0, 5);
        n = ncell;
        if (shape == 0)
            n = ncell + $urandom_range(1, 6);
        else if (shape == 1 && ncell > 1)
        begin
            n = $urandom_range(1, ncell - 1);
            tail_ok = 1'b1;
            for (int i = n; i < ncell; i++)
                if (!loaded[i])
                    tail_ok = 1'b0;
            if (!tail_ok)
                n = ncell;
        end
        for (int i = 0; i < n; i++)
            send_cell(pick_height(style), i == n - 1);
    endtask

    function automatic logic [SIZE_BITS-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'($urandom_range(65, 127));
            2: return 7'd64;
            default: return 7'($urandom_range(1, 8));
        endcase
    endfunction

    // receiver: changing stall patterns, plus one long hold-off on request
    int rx_mode = 0;
    int rx_left = 0;
    int hold_left = 0;
    always @(posedge clk)
    begin
        if (effort_valid && effort_ready)
            board.check(effort);
        if (hold_req && hold_left == 0)
        begin
            hold_left = 3000;
            hold_req = 1'b0;
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 300);
        end
        else
            rx_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            effort_ready <= 1'b0;
        end
        else if (rx_mode == 0)
            effort_ready <= 1'b1;
        else if (rx_mode == 1)
            effort_ready <= 1'($urandom_range(0, 1));
        else
            effort_ready <= ($urandom_range(0, 7) == 0);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [SIZE_BITS-1:0] r, c;
        int grids;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset size 1x1, zero sizes, extreme heights, extra cells
        send_cell(16'hFFFF, 1'b1);
        set_size(7'd0, 7'd0);
        send_cell(16'h0000, 1'b1);
        set_size(7'd2, 7'd2);
        send_cell(16'h0000, 1'b0);
        send_cell(16'hFFFF, 1'b0);
        send_cell(16'hFFFF, 1'b0);
        send_cell(16'h0000, 1'b1);
        send_cell(16'h0000, 1'b0);
        send_cell(16'hFFFF, 1'b0);
        send_cell(16'h8000, 1'b0);
        send_cell(16'h7FFF, 1'b0);
        send_cell(16'h5555, 1'b0);
        send_cell(16'hAAAA, 1'b1);
        // short grid over already loaded cells
        send_cell(16'h1234, 1'b1);
        set_size(7'd1, 7'd3);
        send_cell(16'h0010, 1'b0);
        send_cell(16'h0000, 1'b0);
        send_cell(16'h0020, 1'b1);

        grids = 0;
        while (items_sent < 700 || grids <= 12)
        begin
            if (grids == 12)
                set_size(7'd1, 7'd64);
            else if ($urandom_range(0, 2) == 0 || grids == 0)
            begin
                r = pick_dim();
                c = pick_dim();
                if (clamp_dim(r, DEF_MAX_ROWS) * clamp_dim(c, DEF_MAX_COLS) > 96)
                    c = $urandom_range(0, 1) ? 7'd1 : 7'd0;
                set_size(r, c);
            end
            if (grids == 5)
                hold_req = 1'b1;
            send_grid();
            if (grids == 12)
                set_size(7'd3, 7'd3);
            grids++;
        end

        cell_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* filelist.f */
sv/gmep_pkg.sv
sv/gmep_relax.sv
sv/grid_min_effort_path.sv
sim/testbench.sv
